/* rtl/fp8dp_pkg.sv */
// Package for the E4M3 dot-product unit: format and fixed-point constants.
`default_nettype none

package fp8dp_pkg;

   // E4M3 field layout
   localparam int BYTE_W      = 8;
   localparam int EXP_W       = 4;
   localparam int MANT_W      = 3;
   localparam int EXP_BIAS    = 7;
   localparam int EXP_MAX     = 15;

   // One clamped product weighs at most 2^17 accumulator LSBs (LSB = 2^-9)
   localparam int PROD_LOG    = 17;
   localparam int PROD_W      = PROD_LOG + 1;

   // Significand product: 4 x 4 bits
   localparam int SIG_W       = MANT_W + 1;
   localparam int SIGPROD_W   = 2 * SIG_W;

   // Product exponent sum (ea + eb + carries), thresholds on the raw biased sum
   localparam int ESUM_W      = EXP_W + 2;
   localparam int ESUM_ZERO   = EXP_BIAS;              // at or below: product is +0
   localparam int ESUM_SAT    = EXP_BIAS + EXP_MAX;    // at or above: product saturates
   localparam int ESUM_SHIFT0 = EXP_BIAS + 1;          // biased exponent 1 -> shift 0

   localparam int MAX_TERMS_DEFAULT = 4;

endpackage : fp8dp_pkg

`default_nettype wire

/* rtl/fp8_e4m3_dot_product.sv */
// E4M3 dot-product unit: pipelined multiply, fixed-point accumulate, E4M3 conversion.
//
//   channel | ports                                               | direction
//   --------+-----------------------------------------------------+----------
//   req     | req_valid, req_stall, req_first_operand,            | in
//           | req_second_operand, req_last_term                   |
//   rsp     | rsp_valid, rsp_stall, rsp_dot_result                | out
//
// One request is accepted per cycle while req_stall is low. A request passes an input
// register, a product register, then the accumulator; a last term moves the sum into a
// conversion register, and from there its result passes to the output register. Reset
// (synchronous) clears all valid flags and the accumulator. A stalled output only holds
// back stages whose contents must reach it; non-last terms keep flowing into the
// accumulator.
`default_nettype none

module fp8_e4m3_dot_product #(
   parameter int MAX_TERMS = fp8dp_pkg::MAX_TERMS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_first_operand,
   input  wire logic [7:0]  req_second_operand,
   input  wire logic        req_last_term,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_dot_result
);

   localparam int PROD_W = fp8dp_pkg::PROD_W;
   localparam int SUM_W  = $clog2((MAX_TERMS + 1) * (2 ** fp8dp_pkg::PROD_LOG) + 1) + 1;
   localparam int MAG_W  = SUM_W - 1;
   localparam int P_W    = $clog2(MAG_W);
   localparam int E8_W   = P_W + 1;
   localparam logic signed [SUM_W-1:0] LIMIT =
      SUM_W'(MAX_TERMS * (2 ** fp8dp_pkg::PROD_LOG));

   // ---------------------------------------------------------------
   // Pipeline control
   // ---------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic s2_last_ff;
   logic out_can, s3_can, s3_move, s2_move, s2_can, s1_move, s1_can;

   always_comb begin
      out_can = !rsp_valid_ff || !rsp_stall;
      s3_move = s3_valid_ff && out_can;
      s3_can  = !s3_valid_ff || out_can;
      s2_move = s2_valid_ff && (!s2_last_ff || s3_can);
      s2_can  = !s2_valid_ff || s2_move;
      s1_move = s1_valid_ff && s2_can;
      s1_can  = !s1_valid_ff || s1_move;
   end

   assign req_stall = !s1_can;
   assign rsp_valid = rsp_valid_ff;

   // ---------------------------------------------------------------
   // Stage 1: input register
   // ---------------------------------------------------------------
   logic [7:0] s1_a_ff, s1_b_ff;
   logic       s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_can) begin
         s1_valid_ff <= req_valid;
      end
      if (s1_can && req_valid) begin
         s1_a_ff    <= req_first_operand;
         s1_b_ff    <= req_second_operand;
         s1_last_ff <= req_last_term;
      end
   end

   // ---------------------------------------------------------------
   // Product: 4x4 significand multiply, renormalize, round half up
   // ---------------------------------------------------------------
   logic [3:0]        sig_a, sig_b;
   logic [7:0]        sig_prod;
   logic              norm;
   logic [6:0]        sig_norm;
   logic [7:0]        sig_rnd;
   logic              rnd_carry;
   logic [3:0]        sig4;
   logic [5:0]        esum;
   logic [3:0]        shamt;
   logic [PROD_W-1:0] prod_mag_in;
   logic              prod_neg_in;

   always_comb begin
      sig_a     = {1'b1, s1_a_ff[2:0]};
      sig_b     = {1'b1, s1_b_ff[2:0]};
      sig_prod  = sig_a * sig_b;
      norm      = sig_prod[7];
      sig_norm  = norm ? sig_prod[7:1] : sig_prod[6:0];
      sig_rnd   = {1'b0, sig_norm} + 8'd4;
      rnd_carry = sig_rnd[7];
      sig4      = rnd_carry ? 4'd8 : sig_rnd[6:3];
      esum      = {2'b00, s1_a_ff[6:3]} + {2'b00, s1_b_ff[6:3]}
                  + 6'(norm) + 6'(rnd_carry);
      shamt     = 4'(esum - 6'(fp8dp_pkg::ESUM_SHIFT0));
      prod_neg_in = s1_a_ff[7] ^ s1_b_ff[7];
      if (esum <= 6'(fp8dp_pkg::ESUM_ZERO)) begin
         prod_mag_in = '0;
      end else if (esum >= 6'(fp8dp_pkg::ESUM_SAT)) begin
         prod_mag_in = PROD_W'(1) << fp8dp_pkg::PROD_LOG;
      end else begin
         prod_mag_in = PROD_W'(sig4) << shamt;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: product register
   // ---------------------------------------------------------------
   logic [PROD_W-1:0] s2_mag_ff;
   logic              s2_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_can) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_can && s1_valid_ff) begin
         s2_mag_ff  <= prod_mag_in;
         s2_neg_ff  <= prod_neg_in;
         s2_last_ff <= s1_last_ff;
      end
   end

   // ---------------------------------------------------------------
   // Accumulate with saturation at +/- MAX_TERMS * 2^17
   // ---------------------------------------------------------------
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic signed [SUM_W-1:0] prod_ext, sum_raw, sum_sat;

   always_comb begin
      prod_ext = SUM_W'(s2_mag_ff);
      if (s2_neg_ff) begin
         prod_ext = -prod_ext;
      end
      sum_raw = acc_ff + prod_ext;
      if (sum_raw > LIMIT) begin
         sum_sat = LIMIT;
      end else if (sum_raw < -LIMIT) begin
         sum_sat = -LIMIT;
      end else begin
         sum_sat = sum_raw;
      end
      acc_in = acc_ff;
      if (s2_move) begin
         acc_in = s2_last_ff ? '0 : sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: final sum register
   // ---------------------------------------------------------------
   logic signed [SUM_W-1:0] s3_sum_ff;
   logic                    s3_load;

   assign s3_load = s2_move && s2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_can) begin
         s3_valid_ff <= s3_load;
      end
      if (s3_load) begin
         s3_sum_ff <= sum_sat;
      end
   end

   // ---------------------------------------------------------------
   // Convert sum to E4M3: magnitude, leading one, normalize, round
   // ---------------------------------------------------------------
   logic signed [SUM_W-1:0] neg_sum;
   logic [MAG_W-1:0]        mag, mag_norm;
   logic [P_W-1:0]          lead;
   logic [4:0]              q5;
   logic [E8_W-1:0]         exp8;
   logic [2:0]              mant_out;
   logic [3:0]              exp_out;
   logic [7:0]              result_in;

   always_comb begin
      neg_sum = -s3_sum_ff;
      mag     = s3_sum_ff[SUM_W-1] ? neg_sum[MAG_W-1:0] : s3_sum_ff[MAG_W-1:0];
      lead    = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (mag[i]) begin
            lead = P_W'(i);
         end
      end
      mag_norm = mag << (P_W'(MAG_W - 1) - lead);
      q5       = {1'b0, mag_norm[MAG_W-1:MAG_W-4]} + 5'(mag_norm[MAG_W-5]);
      exp8     = E8_W'(lead) - E8_W'(2) + E8_W'(q5[4]);
      mant_out = q5[4] ? 3'd0 : q5[2:0];
      exp_out  = (exp8 > E8_W'(fp8dp_pkg::EXP_MAX)) ? 4'(fp8dp_pkg::EXP_MAX) : exp8[3:0];
      if (lead < P_W'(3)) begin
         // zero or below the smallest normal exponent
         result_in = 8'h00;
      end else begin
         result_in = {s3_sum_ff[SUM_W-1], exp_out, mant_out};
      end
   end

   // ---------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------
   logic [7:0] rsp_result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_can) begin
         rsp_valid_ff <= s3_valid_ff;
      end
      if (s3_move) begin
         rsp_result_ff <= result_in;
      end
   end

   assign rsp_dot_result = rsp_result_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_acc_in_range: assert property (@(posedge clock) disable iff (reset)
      (acc_ff <= LIMIT) && (acc_ff >= -LIMIT))
      else $error("accumulator outside saturation range");

   a_acc_clears: assert property (@(posedge clock) disable iff (reset)
      (s2_move && s2_last_ff) |=> (acc_ff == '0))
      else $error("accumulator not cleared after last term");

   a_no_exp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_result_ff[6:3] != 4'd0) || (rsp_result_ff == 8'h00)))
      else $error("result with exponent code 0 that is not zero");

endmodule : fp8_e4m3_dot_product

`default_nettype wire

/* sim/fp8_e4m3_dot_product_tb.sv */
// Testbench for the E4M3 dot-product unit: directed and random dot products, checked in order.
`timescale 1ns / 1ps

module fp8_e4m3_dot_product_tb;

   localparam int TERMS       = fp8dp_pkg::MAX_TERMS_DEFAULT;
   localparam int SUM_LIMIT   = TERMS * (1 << fp8dp_pkg::PROD_LOG);
   localparam int ITEM_TARGET = 1950;
   localparam int MAX_GAP     = 17;
   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_WAIT  = 10;

   // Predicts each dot product and checks results in order
   class dot_checker;
      logic signed [20:0] partial_sum;
      logic [7:0]         expected_bytes[$];
      int                 failures;

      function new();
         partial_sum = '0;
         failures    = 0;
      endfunction

      // Signed product in accumulator LSBs (2^-9)
      function int product_lsbs(logic [7:0] a, logic [7:0] b);
         logic       neg;
         logic [7:0] sig_prod;
         int         expo;
         int         frac;
         int         mag;
         neg      = a[7] ^ b[7];
         sig_prod = {4'b0001, a[fp8dp_pkg::MANT_W-1:0]}
                    * {4'b0001, b[fp8dp_pkg::MANT_W-1:0]};
         expo     = int'(a[6:3]) + int'(b[6:3]) - fp8dp_pkg::EXP_BIAS;
         if (sig_prod[7]) begin
            sig_prod = sig_prod >> 1;
            expo++;
         end
         frac = (int'(sig_prod) + 4) >> 3;
         if (frac >= 16) begin
            frac = 0;
            expo++;
         end else begin
            frac = frac & 7;
         end
         if (expo <= 0) return 0;
         if (expo >= fp8dp_pkg::EXP_MAX) mag = 1 << fp8dp_pkg::PROD_LOG;
         else mag = (8 + frac) << (expo - 1);
         return neg ? -mag : mag;
      endfunction

      // Round the fixed-point sum to an E4M3 byte
      function logic [7:0] encode_sum(int sum);
         logic       neg;
         int         mag;
         int         msb;
         int         q;
         int         expo;
         if (sum == 0) return 8'h00;
         neg = sum < 0;
         mag = neg ? -sum : sum;
         msb = 0;
         for (int i = 0; i < 31; i++)
            if (mag[i]) msb = i;
         if (msb < 3) return 8'h00;
         if (msb == 3) q = mag;
         else q = (mag + (1 << (msb - 4))) >> (msb - 3);
         expo = msb - 2;
         if (q >= 16) begin
            q = 8;
            expo++;
         end
         if (expo > fp8dp_pkg::EXP_MAX) expo = fp8dp_pkg::EXP_MAX;
         return {neg, 4'(expo), 3'(q)};
      endfunction

      function void note_request(logic [7:0] a, logic [7:0] b, logic last);
         int s;
         s = int'(partial_sum) + product_lsbs(a, b);
         if (s > SUM_LIMIT) s = SUM_LIMIT;
         if (s < -SUM_LIMIT) s = -SUM_LIMIT;
         if (last) begin
            expected_bytes.push_back(encode_sum(s));
            partial_sum = '0;
         end else begin
            partial_sum = 21'(s);
         end
      endfunction

      function void check_result(logic [7:0] actual);
         logic [7:0] want;
         if (expected_bytes.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: unexpected result 0x%02h", $realtime, actual);
            return;
         end
         want = expected_bytes.pop_front();
         if (actual !== want) begin
            failures++;
            if (failures <= 10)
               $display("%0t: dot_result mismatch: expected 0x%02h, got 0x%02h",
                        $realtime, want, actual);
         end
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction
   endclass

   logic       clock              = 1'b0;
   logic       reset              = 1'b1;
   logic       req_valid          = 1'b0;
   logic       req_stall;
   logic [7:0] req_first_operand  = 8'h00;
   logic [7:0] req_second_operand = 8'h00;
   logic       req_last_term      = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall          = 1'b0;
   logic [7:0] rsp_dot_result;

   dot_checker sb = new();
   int         items_sent  = 0;
   bit         sender_lazy = 1'b0;
   bit         rsp_lazy    = 1'b0;
   int         idle_cycles = 0;

   // Directed dot products: {last, first, second}
   logic [16:0] directed [21] = '{
      {1'b1, 8'h00, 8'h00},                        // exponent code 0 still has a hidden one
      {1'b1, 8'h7F, 8'h7F},                        // product saturates
      {1'b1, 8'hFF, 8'h7F},                        // negative saturated product
      {1'b1, 8'h3F, 8'h3F},                        // significand renormalizes
      {1'b1, 8'h39, 8'h3E},                        // rounding carries into exponent
      {1'b0, 8'h38, 8'h38}, {1'b1, 8'hB8, 8'h38},  // sum cancels to zero
      {1'b0, 8'h20, 8'h20}, {1'b1, 8'hA1, 8'h20},  // tiny sum flushes
      {1'b0, 8'h7F, 8'h7F}, {1'b0, 8'h7F, 8'h7F},  // huge sum clamps exponent
      {1'b0, 8'h7F, 8'h7F}, {1'b1, 8'h7F, 8'h7F},
      {1'b0, 8'h7F, 8'h7F}, {1'b0, 8'h7F, 8'h7F},  // accumulator saturation
      {1'b0, 8'h7F, 8'h7F}, {1'b0, 8'h7F, 8'h7F},
      {1'b0, 8'h7F, 8'h7F}, {1'b0, 8'h7F, 8'h7F},
      {1'b1, 8'hFF, 8'h7F},
      {1'b1, 8'h10, 8'h08}                         // product underflows to zero
   };

   fp8_e4m3_dot_product #(.MAX_TERMS(TERMS)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_first_operand  (req_first_operand),
      .req_second_operand (req_second_operand),
      .req_last_term      (req_last_term),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_dot_result     (rsp_dot_result)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Present one request and hold it until accepted
   task automatic send_request(input logic [7:0] a, input logic [7:0] b, input logic last);
      int gap;
      gap = sender_lazy ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_first_operand  <= a;
      req_second_operand <= b;
      req_last_term      <= last;
      do @(posedge clock); while (req_stall);
      sb.note_request(a, b, last);
      items_sent++;
   endtask

   // Stop sending until every outstanding result is back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Operand with exponent mostly near the bias so sums stay in range
   function automatic logic [7:0] pick_operand();
      logic [3:0] ex;
      if ($urandom_range(0, 9) < 6) ex = 4'($urandom_range(3, 11));
      else ex = 4'($urandom_range(0, 15));
      return {1'($urandom_range(0, 1)), ex, 3'($urandom_range(0, 7))};
   endfunction

   // Main stimulus
   initial begin
      int len;
      bit paused;
      paused = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_request(directed[i][15:8], directed[i][7:0], directed[i][16]);
      drain_results();

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 7) == 0) sender_lazy = ~sender_lazy;
         if ($urandom_range(0, 9) == 0) len = $urandom_range(TERMS + 1, 3 * TERMS);
         else len = $urandom_range(1, TERMS + 2);
         for (int i = 0; i < len; i++)
            send_request(pick_operand(), pick_operand(), i == len - 1);
         if (!paused && items_sent > ITEM_TARGET / 2) begin
            drain_results();
            paused = 1'b1;
         end
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Result side: random stall before each result
   initial begin
      int hold;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 19) == 0) rsp_lazy = ~rsp_lazy;
         hold = rsp_lazy ? $urandom_range(0, MAX_GAP) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_dot_result);
   end

   // Watchdog on cycles with no request or result moving
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

endmodule

/* filelist.f */
rtl/fp8dp_pkg.sv
rtl/fp8_e4m3_dot_product.sv
sim/fp8_e4m3_dot_product_tb.sv
